[src/pafan_pkg.sv]
`timescale 1ns / 1ps
// pafan_pkg: widths, payload structs and shared types for the polygon area block
// depends on nothing; used by every module under src

package pafan_pkg;

    localparam int COORD_BITS = 16;
    localparam int AREA_BITS  = 48;

    localparam int AXES   = 3;
    localparam int AXIS_W = $clog2(AXES);

    // corner differences, cross product terms and their magnitudes
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int MAG_W  = PROD_W;
    localparam int MUL_W  = MAG_W + 1;

    // sum of three squares and its square root
    localparam int SUM_W  = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    localparam int ACC_W = ((AREA_BITS > ROOT_W) ? AREA_BITS : ROOT_W) + 1;
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    // corners taken so far in the current polygon
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MANY = 2'd2;

    typedef logic [AXES-1:0][COORD_BITS-1:0] coord_vec_t;
    typedef logic [AXES-1:0][DIFF_W-1:0]     diff_vec_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner_x;
        logic signed [COORD_BITS-1:0] corner_y;
        logic signed [COORD_BITS-1:0] corner_z;
        logic                         last_corner;
    } corner_t;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 saturated;
    } result_t;

    // handshake of the two iterative units toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

[src/polygon_area_fan_triangulation.sv]
`timescale 1ns / 1ps
// polygon_area_fan_triangulation: top level, corner sequencer and area accumulator
// depends on pafan_pkg, pafan_cross, pafan_isqrt
//
//   channel  | signals                                   | moves
//   ---------+-------------------------------------------+-----------------------------
//   corner   | corner_valid, corner_ready, corner_data  | one polygon corner per request
//   result   | result_valid, result_ready, result_data  | area and flag on last corner
//
// the first two corners of a polygon are only stored; a last one among them
// goes to the finish state before ready returns
// every later corner takes 15 steps of the shared multiplier
// (two products, a subtract, a square and an add per cross component),
// 34 steps of the bit-serial square root and the add and finish sequencer states
// rst_n clears the sequencer, the corner count and the running sum
// a finished result sits in the output register while the next corner is taken;
// only a last corner waits there if the previous result has not yet been taken

module polygon_area_fan_triangulation
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   corner_valid,
    output logic                   corner_ready,
    input  pafan_pkg::corner_t     corner_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output pafan_pkg::result_t     result_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CROSS,
        S_ROOT,
        S_ADD,
        S_FIN
    } state_t;

    state_t                             state_reg;
    pafan_pkg::coord_vec_t              first_reg;
    pafan_pkg::coord_vec_t              prev_reg;
    pafan_pkg::coord_vec_t              cur_reg;
    logic                               last_reg;
    logic [1:0]                         seen_reg;
    logic [pafan_pkg::AREA_BITS-1:0]    area_sum_reg;
    logic                               sum_sat_reg;
    logic                               out_valid_reg;
    pafan_pkg::result_t                 out_reg;

    pafan_pkg::coord_vec_t              corner_vec;
    pafan_pkg::diff_vec_t               u_vec;
    pafan_pkg::diff_vec_t               v_vec;
    logic                               accept;
    logic                               cross_start;
    pafan_pkg::unit_status_t            cross_st;
    pafan_pkg::unit_status_t            root_st;
    logic [pafan_pkg::SUM_W-1:0]        sum_sq;
    logic [pafan_pkg::ROOT_W-1:0]       root;
    logic [pafan_pkg::ACC_W-1:0]        acc_sum;
    logic [pafan_pkg::AREA_BITS-1:0]    new_sum;
    logic                               out_free;
    logic                               out_load;

    // axis 0 is x, 1 is y, 2 is z
    assign corner_vec[0] = corner_data.corner_x;
    assign corner_vec[1] = corner_data.corner_y;
    assign corner_vec[2] = corner_data.corner_z;

    assign corner_ready = (state_reg == S_IDLE);
    assign accept       = corner_valid && corner_ready;
    assign cross_start  = accept && (seen_reg == pafan_pkg::SEEN_MANY);
    assign out_free     = !out_valid_reg || result_ready;
    // polygon closed and the output register can take its sum
    assign out_load     = (state_reg == S_FIN) && last_reg && out_free;

    // fan edges: first minus previous and first minus current, one extra bit
    always_comb
    begin
        for (int i = 0; i < pafan_pkg::AXES; i++)
        begin
            u_vec[i] = {first_reg[i][pafan_pkg::COORD_BITS-1], first_reg[i]}
                     - {prev_reg[i][pafan_pkg::COORD_BITS-1], prev_reg[i]};
            v_vec[i] = {first_reg[i][pafan_pkg::COORD_BITS-1], first_reg[i]}
                     - {cur_reg[i][pafan_pkg::COORD_BITS-1], cur_reg[i]};
        end
    end

    // squared length of the cross product
    pafan_cross u_cross
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cross_start),
        .u_vec  (u_vec),
        .v_vec  (v_vec),
        .status (cross_st),
        .sum_sq (sum_sq)
    );

    // twice the triangle area is the floor root of that length
    pafan_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cross_st.done),
        .radicand (sum_sq),
        .status   (root_st),
        .root     (root)
    );

    // saturating add, the extra top bit catches overflow
    assign acc_sum = pafan_pkg::ACC_W'(area_sum_reg) + pafan_pkg::ACC_W'(root);
    assign new_sum = (acc_sum > pafan_pkg::ACC_W'(pafan_pkg::AREA_MAX))
                   ? pafan_pkg::AREA_MAX
                   : acc_sum[pafan_pkg::AREA_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            last_reg      <= 1'b0;
            seen_reg      <= pafan_pkg::SEEN_NONE;
            area_sum_reg  <= '0;
            sum_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg  <= corner_vec;
                        last_reg <= corner_data.last_corner;
                        case (seen_reg)
                            pafan_pkg::SEEN_NONE:
                            begin
                                first_reg <= corner_vec;
                                prev_reg  <= corner_vec;
                                seen_reg  <= pafan_pkg::SEEN_ONE;
                                if (corner_data.last_corner)
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            pafan_pkg::SEEN_ONE:
                            begin
                                prev_reg <= corner_vec;
                                seen_reg <= pafan_pkg::SEEN_MANY;
                                if (corner_data.last_corner)
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default:
                            begin
                                // third corner on: a new fan triangle
                                state_reg <= S_CROSS;
                            end
                        endcase
                    end
                end
                S_CROSS:
                begin
                    if (cross_st.done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_st.done)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    area_sum_reg <= new_sum;
                    if (new_sum == pafan_pkg::AREA_MAX)
                    begin
                        sum_sat_reg <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    prev_reg <= cur_reg;
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        // polygon closed: hand out the sum and start over
                        out_reg.area      <= area_sum_reg;
                        out_reg.saturated <= sum_sat_reg;
                        seen_reg          <= pafan_pkg::SEEN_NONE;
                        area_sum_reg      <= '0;
                        sum_sat_reg       <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

`ifndef NO_ASSERTIONS
    // the sticky flag is only ever set together with a full sum
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_sat_reg |-> (area_sum_reg == pafan_pkg::AREA_MAX))
        else $error("saturation flag set without a full sum");

    // a corner from the third on goes straight to the cross product
    assert property (@(posedge clk) disable iff (!rst_n)
        cross_start |=> (state_reg == S_CROSS))
        else $error("triangle corner did not start the cross product");

    assert property (@(posedge clk) disable iff (!rst_n)
        cross_st.done |-> (state_reg == S_CROSS))
        else $error("cross product finished outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_st.done |-> (state_reg == S_ROOT))
        else $error("square root finished outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.saturated) |->
            (result_data.area == pafan_pkg::AREA_MAX))
        else $error("saturated result without maximum area");
`endif

endmodule

[src/pafan_isqrt.sv]
`timescale 1ns / 1ps
// pafan_isqrt: bit-serial floor square root, one result bit per cycle
// depends on pafan_pkg

module pafan_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pafan_pkg::SUM_W-1:0]       radicand,
    output pafan_pkg::unit_status_t           status,
    output logic [pafan_pkg::ROOT_W-1:0]      root
);

    logic [pafan_pkg::SUM_W-1:0]    rad_reg;
    logic [pafan_pkg::ROOT_W+1:0]   rem_reg;
    logic [pafan_pkg::ROOT_W-1:0]   root_reg;
    logic [pafan_pkg::CNT_W-1:0]    cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [pafan_pkg::ROOT_W+1:0]   rem_sh;
    logic [pafan_pkg::ROOT_W+1:0]   trial;
    logic                           take;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[pafan_pkg::ROOT_W-1:0], rad_reg[pafan_pkg::SUM_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= pafan_pkg::CNT_W'(pafan_pkg::ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[pafan_pkg::ROOT_W-2:0], take};
                cnt_reg  <= cnt_reg - pafan_pkg::CNT_W'(1);
                if (cnt_reg == pafan_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

[src/pafan_cross.sv]
`timescale 1ns / 1ps
// pafan_cross: squared length of a cross product through one shared multiplier
// depends on pafan_pkg

module pafan_cross
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  pafan_pkg::diff_vec_t            u_vec,
    input  pafan_pkg::diff_vec_t            v_vec,
    output pafan_pkg::unit_status_t         status,
    output logic [pafan_pkg::SUM_W-1:0]     sum_sq
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL_A,
        PH_MUL_B,
        PH_DIFF,
        PH_SQ,
        PH_ACC
    } phase_t;

    phase_t                                 phase_reg;
    logic [pafan_pkg::AXIS_W-1:0]           comp_reg;
    logic                                   done_reg;
    logic signed [2*pafan_pkg::MUL_W-1:0]   prod_reg;
    logic signed [pafan_pkg::PROD_W-1:0]    hold_reg;
    logic signed [pafan_pkg::PROD_W-1:0]    cross_reg;
    logic [pafan_pkg::SUM_W-1:0]            sum_reg;

    logic [pafan_pkg::AXIS_W-1:0]           idx_a;
    logic [pafan_pkg::AXIS_W-1:0]           idx_b;
    logic [pafan_pkg::MAG_W-1:0]            mag_w;
    logic signed [pafan_pkg::MUL_W-1:0]     op_l;
    logic signed [pafan_pkg::MUL_W-1:0]     op_r;
    logic signed [2*pafan_pkg::MUL_W-1:0]   mul_out;

    function automatic logic signed [pafan_pkg::MUL_W-1:0] sext_diff(
        input logic [pafan_pkg::DIFF_W-1:0] d
    );
        return $signed({{(pafan_pkg::MUL_W-pafan_pkg::DIFF_W){d[pafan_pkg::DIFF_W-1]}}, d});
    endfunction

    // component k is u[k+1]*v[k+2] - u[k+2]*v[k+1], indices mod 3
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin idx_a = 2'd1; idx_b = 2'd2; end
            2'd1:    begin idx_a = 2'd2; idx_b = 2'd0; end
            2'd2:    begin idx_a = 2'd0; idx_b = 2'd1; end
            default: begin idx_a = 2'd1; idx_b = 2'd2; end
        endcase
    end

    assign mag_w = cross_reg[pafan_pkg::PROD_W-1] ? pafan_pkg::MAG_W'(-cross_reg)
                                                  : pafan_pkg::MAG_W'(cross_reg);

    always_comb
    begin
        unique case (phase_reg)
            PH_MUL_A:
            begin
                op_l = sext_diff(u_vec[idx_a]);
                op_r = sext_diff(v_vec[idx_b]);
            end
            PH_MUL_B:
            begin
                op_l = sext_diff(u_vec[idx_b]);
                op_r = sext_diff(v_vec[idx_a]);
            end
            default:
            begin
                op_l = $signed({1'b0, mag_w});
                op_r = $signed({1'b0, mag_w});
            end
        endcase
    end

    assign mul_out = op_l * op_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            comp_reg  <= '0;
            done_reg  <= 1'b0;
            prod_reg  <= '0;
            hold_reg  <= '0;
            cross_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg   <= '0;
                        comp_reg  <= '0;
                        phase_reg <= PH_MUL_A;
                    end
                end
                PH_MUL_A:
                begin
                    prod_reg  <= mul_out;
                    phase_reg <= PH_MUL_B;
                end
                PH_MUL_B:
                begin
                    hold_reg  <= prod_reg[pafan_pkg::PROD_W-1:0];
                    prod_reg  <= mul_out;
                    phase_reg <= PH_DIFF;
                end
                PH_DIFF:
                begin
                    cross_reg <= hold_reg - $signed(prod_reg[pafan_pkg::PROD_W-1:0]);
                    phase_reg <= PH_SQ;
                end
                PH_SQ:
                begin
                    prod_reg  <= mul_out;
                    phase_reg <= PH_ACC;
                end
                PH_ACC:
                begin
                    sum_reg <= sum_reg + prod_reg[pafan_pkg::SUM_W-1:0];
                    if (comp_reg == pafan_pkg::AXIS_W'(pafan_pkg::AXES - 1))
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + pafan_pkg::AXIS_W'(1);
                        phase_reg <= PH_MUL_A;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (phase_reg != PH_IDLE);
    assign status.done = done_reg;
    assign sum_sq      = sum_reg;

endmodule

[dv/pafan_area_checker.sv]
`timescale 1ns / 1ps
// pafan_area_checker: watches the corner and result channels of the polygon area block,
// predicts each polygon's area from the accepted corners and compares the returned result
// depends on pafan_pkg

module pafan_area_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                corner_valid,
    input  logic                corner_ready,
    input  pafan_pkg::corner_t  corner_data,
    input  logic                result_valid,
    input  logic                result_ready,
    input  pafan_pkg::result_t  result_data,
    output int                  fail_count,
    output int                  areas_pending,
    output int                  corners_taken,
    output int                  areas_checked,
    output int                  saturated_seen
);

    typedef struct packed {
        logic signed [pafan_pkg::COORD_BITS-1:0] x;
        logic signed [pafan_pkg::COORD_BITS-1:0] y;
        logic signed [pafan_pkg::COORD_BITS-1:0] z;
    } point_t;

    // polygon being assembled
    point_t                          apex_pt;
    point_t                          prev_pt;
    logic [1:0]                      seen;
    logic [pafan_pkg::AREA_BITS-1:0] area_sum;
    logic                            sum_clamped;

    pafan_pkg::result_t expected_areas [$];

    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0] root;
        logic [63:0] cand;
        int          b;
        root = '0;
        for (b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n)
                root = cand;
        end
        return root;
    endfunction

    // length of (apex - prev) x (apex - cur), i.e. twice the triangle area
    function automatic logic [63:0] twice_triangle_area(input point_t apex, input point_t prev,
                                                        input point_t cur);
        logic signed [63:0] ux, uy, uz, vx, vy, vz;
        logic signed [63:0] cx, cy, cz;
        logic [63:0]        ax, ay, az;
        logic [127:0]       sq_len;
        ux = $signed(apex.x) - $signed(prev.x);
        uy = $signed(apex.y) - $signed(prev.y);
        uz = $signed(apex.z) - $signed(prev.z);
        vx = $signed(apex.x) - $signed(cur.x);
        vy = $signed(apex.y) - $signed(cur.y);
        vz = $signed(apex.z) - $signed(cur.z);
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        ax = (cx < 0) ? -cx : cx;
        ay = (cy < 0) ? -cy : cy;
        az = (cz < 0) ? -cz : cz;
        sq_len = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay}
               + {64'd0, az} * {64'd0, az};
        return floor_sqrt(sq_len);
    endfunction

    task automatic clear_polygon();
        apex_pt     = '0;
        prev_pt     = '0;
        seen        = pafan_pkg::SEEN_NONE;
        area_sum    = '0;
        sum_clamped = 1'b0;
    endtask

    task automatic take_corner(input pafan_pkg::corner_t c);
        point_t             cur;
        logic [63:0]        twice;
        logic [63:0]        headroom;
        pafan_pkg::result_t want;
        cur.x = c.corner_x;
        cur.y = c.corner_y;
        cur.z = c.corner_z;
        corners_taken++;
        case (seen)
            pafan_pkg::SEEN_NONE:
            begin
                apex_pt = cur;
                seen    = pafan_pkg::SEEN_ONE;
            end
            pafan_pkg::SEEN_ONE:
                seen = pafan_pkg::SEEN_MANY;
            default:
            begin
                twice    = twice_triangle_area(apex_pt, prev_pt, cur);
                headroom = pafan_pkg::AREA_MAX - area_sum;
                if (twice > headroom)
                    area_sum = pafan_pkg::AREA_MAX;
                else
                    area_sum = area_sum + twice;
                if (area_sum == pafan_pkg::AREA_MAX)
                    sum_clamped = 1'b1;
            end
        endcase
        prev_pt = cur;
        if (c.last_corner)
        begin
            want.area      = area_sum;
            want.saturated = sum_clamped;
            expected_areas.push_back(want);
            areas_pending++;
            clear_polygon();
        end
    endtask

    task automatic check_area(input pafan_pkg::result_t got);
        pafan_pkg::result_t want;
        if (expected_areas.size() == 0)
        begin
            $error("unexpected result: area %0d saturated %0b", got.area, got.saturated);
            fail_count++;
        end
        else
        begin
            want = expected_areas.pop_front();
            areas_pending--;
            areas_checked++;
            if (want.saturated)
                saturated_seen++;
            if (got.area !== want.area)
            begin
                $error("area: expected %0d, actual %0d", want.area, got.area);
                fail_count++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_polygon();
            expected_areas.delete();
            fail_count     = 0;
            areas_pending  = 0;
            corners_taken  = 0;
            areas_checked  = 0;
            saturated_seen = 0;
        end
        else
        begin
            if (corner_valid && corner_ready)
                take_corner(corner_data);
            if (result_valid && result_ready)
                check_area(result_data);
        end
    end

endmodule

[dv/tb_polygon_area_fan_triangulation.sv]
`timescale 1ns / 1ps
// tb_polygon_area_fan_triangulation: drives corner requests into the polygon area block
// and stalls its result side at random; checking is done by pafan_area_checker
// depends on pafan_pkg, pafan_area_checker and the block under src

module tb_polygon_area_fan_triangulation;

    // how the coordinates of one random polygon are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_TIGHT,
        SPREAD_EXTREME,
        SPREAD_PLANAR
    } spread_t;

    // fan triangles of a large size spanning the coordinate cube
    localparam int LARGE_TRIANGLES = 40;
    // drain margin for a later corner plus the longest result stall
    localparam int DRAIN_CYCLES    = 150;
    localparam int RANDOM_ITEMS    = 890;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               corner_valid = 1'b0;
    logic               corner_ready;
    pafan_pkg::corner_t corner_data  = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    pafan_pkg::result_t result_data;

    // idling: longest gap before each corner request and longest stall per result
    int tx_gap_max    = 19;
    int rx_stall_max  = 19;
    int rx_stall_left = 0;

    int check_fails;
    int areas_pending;
    int corners_taken;
    int areas_checked;
    int saturated_seen;
    int random_corners = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    polygon_area_fan_triangulation uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_ready (corner_ready),
        .corner_data  (corner_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    pafan_area_checker area_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .corner_valid   (corner_valid),
        .corner_ready   (corner_ready),
        .corner_data    (corner_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .fail_count     (check_fails),
        .areas_pending  (areas_pending),
        .corners_taken  (corners_taken),
        .areas_checked  (areas_checked),
        .saturated_seen (saturated_seen)
    );

    // result side: after each taken result, hold ready low for a random number of cycles;
    // with a stall of zero ready just stays high into the next result
    always @(posedge clk or negedge rst_n)
    begin
        int stall;
        if (!rst_n)
        begin
            result_ready  <= 1'b0;
            rx_stall_left <= 0;
        end
        else if (result_valid && result_ready)
        begin
            stall = $urandom_range(rx_stall_max, 0);
            rx_stall_left <= stall;
            result_ready  <= (stall == 0);
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            result_ready  <= (rx_stall_left == 1);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    function automatic pafan_pkg::corner_t make_corner(input logic [15:0] x,
                                                       input logic [15:0] y,
                                                       input logic [15:0] z,
                                                       input logic last);
        pafan_pkg::corner_t c;
        c.corner_x    = x;
        c.corner_y    = y;
        c.corner_z    = z;
        c.last_corner = last;
        return c;
    endfunction

    // one corner request; valid drops only when a gap is drawn, so back-to-back
    // requests keep valid high across the handshake edge
    task automatic send_corner(input pafan_pkg::corner_t c);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            corner_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        corner_valid <= 1'b1;
        corner_data  <= c;
        do
            @(posedge clk);
        while (!corner_ready);
    endtask

    function automatic logic [15:0] pick_coord(input spread_t spread);
        logic [15:0] v;
        case (spread)
            SPREAD_TIGHT:
                v = 16'($urandom_range(1023) - 512);
            SPREAD_EXTREME:
                case ($urandom_range(4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'hffff;
                    3:       v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            default:
                v = 16'($urandom_range(65535));
        endcase
        return v;
    endfunction

    // random polygon: mostly 3 to 10 corners, some degenerate ones with one or two,
    // a few long fans; idling on each side is switched off for about a quarter of them
    task automatic send_random_polygon();
        int          len;
        int          roll;
        int          i;
        spread_t     spread;
        logic [15:0] plane_z;
        logic [15:0] z;
        roll = $urandom_range(99);
        if (roll < 8)
            len = 1;
        else if (roll < 16)
            len = 2;
        else if (roll < 92)
            len = $urandom_range(10, 3);
        else
            len = $urandom_range(40, 11);
        spread  = spread_t'($urandom_range(3));
        plane_z = 16'($urandom_range(65535));
        tx_gap_max    = ($urandom_range(3) == 0) ? 0 : 19;
        rx_stall_max <= ($urandom_range(3) == 0) ? 0 : 19;
        for (i = 0; i < len; i++)
        begin
            z = (spread == SPREAD_PLANAR) ? plane_z : pick_coord(spread);
            send_corner(make_corner(pick_coord(spread), pick_coord(spread), z, i == len - 1));
        end
        random_corners += len;
    endtask

    // fan around one cube corner, alternating between two far corners so that every
    // triangle spans the whole coordinate cube; the sum grows large without stalls
    task automatic send_large_fan();
        int i;
        tx_gap_max    = 0;
        rx_stall_max <= 0;
        send_corner(make_corner(16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_corner(make_corner(16'h7fff, 16'h7fff, 16'h8000, 1'b0));
        for (i = 0; i < LARGE_TRIANGLES; i++)
        begin
            if (i % 2 == 0)
                send_corner(make_corner(16'h7fff, 16'h8000, 16'h7fff, i == LARGE_TRIANGLES - 1));
            else
                send_corner(make_corner(16'h7fff, 16'h7fff, 16'h8000, i == LARGE_TRIANGLES - 1));
        end
        tx_gap_max    = 19;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single corner marked last: area is zero
        send_corner(make_corner(16'h8000, 16'h7fff, 16'h0000, 1'b1));
        // two corners only: still zero
        send_corner(make_corner(16'h0001, 16'h0002, 16'h0003, 1'b0));
        send_corner(make_corner(16'hfffb, 16'h0007, 16'h7fff, 1'b1));
        // largest single triangle across the coordinate cube
        send_corner(make_corner(16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_corner(make_corner(16'h7fff, 16'h7fff, 16'h8000, 1'b0));
        send_corner(make_corner(16'h7fff, 16'h8000, 16'h7fff, 1'b1));
        // collinear corners: zero-area triangle
        send_corner(make_corner(16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_corner(make_corner(16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_corner(make_corner(16'h0200, 16'h0200, 16'h0200, 1'b1));
        // square of side 256 in the xy plane
        send_corner(make_corner(16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_corner(make_corner(16'h0100, 16'h0000, 16'h0000, 1'b0));
        send_corner(make_corner(16'h0100, 16'h0100, 16'h0000, 1'b0));
        send_corner(make_corner(16'h0000, 16'h0100, 16'h0000, 1'b1));
        // pentagon at z = -1 touching the range limits
        send_corner(make_corner(16'hffff, 16'hffff, 16'hffff, 1'b0));
        send_corner(make_corner(16'h8000, 16'h0000, 16'hffff, 1'b0));
        send_corner(make_corner(16'hc000, 16'h7fff, 16'hffff, 1'b0));
        send_corner(make_corner(16'h7fff, 16'h4000, 16'hffff, 1'b0));
        send_corner(make_corner(16'h0000, 16'h8000, 16'hffff, 1'b1));

        // long fan of large triangles, then random polygons that start from cleared state
        send_large_fan();
        while (random_corners < RANDOM_ITEMS)
            send_random_polygon();
        corner_valid <= 1'b0;

        @(posedge clk);
        while (areas_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d corners sent, %0d polygon areas compared, %0d of them saturated",
                 corners_taken, areas_checked, saturated_seen);
        $display("directed extremes, one %0d-triangle fan of large triangles, random polygons",
                 LARGE_TRIANGLES);
        if (check_fails == 0 && areas_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // guard against a hung block; the limit lies well beyond a full run with every stall
    initial
    begin
        #(20_000_000);
        $display("timeout waiting for the block");
        $display("Some tests failed");
        $finish;
    end

endmodule
